@@ hdl/exponential_decay_log_linear_fit_unit_assert.svh @@
// assertion macros for the log-linear exponential fit unit
// used by hdl/exponential_decay_log_linear_fit_unit.sv, expects clock and reset in scope
`ifndef EXPONENTIAL_DECAY_LOG_LINEAR_FIT_UNIT_ASSERT_SVH
`define EXPONENTIAL_DECAY_LOG_LINEAR_FIT_UNIT_ASSERT_SVH

// condition and consequence in the same cycle
`define EDLF_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequence in the cycle after the condition
`define EDLF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/edlf_pkg.sv @@
// constants, code types and helpers for the log-linear exponential fit unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package edlf_pkg;

   // samples per voxel set
   localparam int MaxPoints = 16;
   localparam int CntW      = $clog2(MaxPoints + 1);

   // fixed-point constants
   localparam logic [31:0] Ln2Q32    = 32'd2977044472;
   localparam logic [31:0] Log2eQ30  = 32'd1549082005;
   localparam logic [23:0] LevelMax  = 24'hFFFFFF;
   localparam logic [59:0] ExpBias   = 60'h400000000000000;
   localparam logic [31:0] CPosLimit = 32'd201326592;
   localparam logic [31:0] CNegLimit = 32'd150994944;
   localparam int          ShiftBase = 38;

   // iteration counts
   localparam int LogSteps  = 20;
   localparam int TermSteps = 20;
   localparam int QuoW      = 32;

   // products used by the normal-equation solve
   typedef enum logic [2:0] {
      OP_N_SBB   = 3'd0,
      OP_SB_SB   = 3'd1,
      OP_N_SBL   = 3'd2,
      OP_SB_SL   = 3'd3,
      OP_SBB_SL  = 3'd4,
      OP_SB_SBL  = 3'd5
   } prod_op_type;

   // what a divider result feeds
   typedef enum logic [1:0] {
      DU_ADC  = 2'd0,
      DU_C    = 2'd1,
      DU_TERM = 2'd2
   } div_use_type;

   // index of the highest set bit, zero for zero
   function automatic logic [3:0] msb_index(input logic [15:0] x);
      logic [3:0] idx;
      idx = 4'd0;
      for (int i = 0; i < 16; i++) begin
         if (x[i]) begin
            idx = 4'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

@@ hdl/exponential_decay_log_linear_fit_unit.sv @@
// log-linear least-squares fit of a mono-exponential decay, one voxel per set
// depends on edlf_pkg and exponential_decay_log_linear_fit_unit_assert.svh
//
// channel   ports                                           direction
// request   start busy req_b_value req_sample req_last_sample   in (busy out)
// result    rsp_valid rsp_decay_rate rsp_intercept_level rsp_fit_ok out
//
// an accepted sample keeps busy high through 20 squarings of the log
// mantissa plus three products, all on the one 32x32 multiplier
// a sample marked last then runs the solve, most of it the restoring divider
// of 32 quotient bits, used twice for the fit and 20 times for exp
// a zero sample or an overfull set is taken with no busy time unless marked last
// synchronous reset clears the sums, the sequencer and the result strobe
// rsp_valid is high for one cycle per set; the receiver takes it then
`timescale 1ns / 1ps
`default_nettype none

`include "exponential_decay_log_linear_fit_unit_assert.svh"

module exponential_decay_log_linear_fit_unit
   import edlf_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  wire  [15:0]         req_b_value,
   input  wire  [15:0]         req_sample,
   input  wire                 req_last_sample,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_decay_rate,
   output logic [23:0]         rsp_intercept_level,
   output logic                rsp_fit_ok
);

   typedef enum logic [16:0] {
      ST_IDLE      = 17'h00001,
      ST_LOG       = 17'h00002,
      ST_LOG_SCALE = 17'h00004,
      ST_ACC_BL    = 17'h00008,
      ST_ACC_BB    = 17'h00010,
      ST_SOLVE     = 17'h00020,
      ST_PROD      = 17'h00040,
      ST_POST      = 17'h00080,
      ST_DIV_RND   = 17'h00100,
      ST_DIV_INIT  = 17'h00200,
      ST_DIV_STEP  = 17'h00400,
      ST_DIV_POST  = 17'h00800,
      ST_EXP_T     = 17'h01000,
      ST_EXP_U     = 17'h02000,
      ST_EXP_X     = 17'h04000,
      ST_EXP_TERM  = 17'h08000,
      ST_EXP_OUT   = 17'h10000
   } state_type;

   state_type     state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [23:0]   sum_b_ff, sum_b_in;
   logic [39:0]   sum_bb_ff, sum_bb_in;
   logic [25:0]   sum_log_ff, sum_log_in;
   logic [47:0]   sum_bl_ff, sum_bl_in;
   logic          bad_ff, bad_in;
   logic [15:0]   b_ff, b_in;
   logic          last_ff, last_in;
   logic [30:0]   m_ff, m_in;
   logic [19:0]   frac_ff, frac_in;
   logic [3:0]    exp_ff, exp_in;
   logic [4:0]    iter_ff, iter_in;
   logic [19:0]   log_ff, log_in;
   prod_op_type   op_ff, op_in;
   logic          ph_ff, ph_in;
   logic [63:0]   acc_ff, acc_in;
   logic [63:0]   tmp_ff, tmp_in;
   logic [40:0]   d_ff, d_in;
   logic          pos_ff, pos_in;
   logic          cpos_ff, cpos_in;
   logic [31:0]   adc_ff, adc_in;
   logic [71:0]   num_ff, num_in;
   logic [40:0]   den_ff, den_in;
   logic [40:0]   rem_ff, rem_in;
   logic [QuoW-1:0] quo_ff, quo_in;
   logic          sat_ff, sat_in;
   div_use_type   use_ff, use_in;
   logic [31:0]   cmag_ff, cmag_in;
   logic [5:0]    kb_ff, kb_in;
   logic [29:0]   f_ff, f_in;
   logic [29:0]   x_ff, x_in;
   logic [30:0]   term_ff, term_in;
   logic [31:0]   esum_ff, esum_in;
   logic [4:0]    k_ff, k_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_rate_ff, rsp_rate_in;
   logic [23:0]   rsp_level_ff, rsp_level_in;
   logic          rsp_ok_ff, rsp_ok_in;

   // shared multiplier and its operands
   logic [31:0]   mul_a, mul_b;
   logic [63:0]   mul_p;
   logic [47:0]   op_a;
   logic [31:0]   op_b;

   // combinational helpers
   logic [3:0]    e_msb;
   logic [31:0]   m_sq;
   logic [63:0]   diff_aq, diff_qa;
   logic [41:0]   rem_sh;
   logic          rem_ge;
   logic [59:0]   u_val;
   logic [5:0]    shift_v;
   logic [35:0]   rnd_v;
   logic [35:0]   val_v;

   // operand pair for each solve product, a up to 48 bits
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (op_ff)
         OP_N_SBB: begin
            op_a = {8'd0, sum_bb_ff};
            op_b = 32'(cnt_ff);
         end
         OP_SB_SB: begin
            op_a = {24'd0, sum_b_ff};
            op_b = {8'd0, sum_b_ff};
         end
         OP_N_SBL: begin
            op_a = sum_bl_ff;
            op_b = 32'(cnt_ff);
         end
         OP_SB_SL: begin
            op_a = {22'd0, sum_log_ff};
            op_b = {8'd0, sum_b_ff};
         end
         OP_SBB_SL: begin
            op_a = {8'd0, sum_bb_ff};
            op_b = {6'd0, sum_log_ff};
         end
         OP_SB_SBL: begin
            op_a = sum_bl_ff;
            op_b = {8'd0, sum_b_ff};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_LOG: begin
            mul_a = {1'b0, m_ff};
            mul_b = {1'b0, m_ff};
         end
         ST_LOG_SCALE: begin
            mul_a = {8'd0, exp_ff, frac_ff};
            mul_b = Ln2Q32;
         end
         ST_ACC_BL: begin
            mul_a = {16'd0, b_ff};
            mul_b = {12'd0, log_ff};
         end
         ST_ACC_BB: begin
            mul_a = {16'd0, b_ff};
            mul_b = {16'd0, b_ff};
         end
         ST_PROD: begin
            mul_a = ph_ff ? {16'd0, op_a[47:32]} : op_a[31:0];
            mul_b = op_b;
         end
         ST_EXP_T: begin
            mul_a = cmag_ff;
            mul_b = Log2eQ30;
         end
         ST_EXP_X: begin
            mul_a = {2'd0, f_ff};
            mul_b = Ln2Q32;
         end
         ST_EXP_TERM: begin
            mul_a = {1'b0, term_ff};
            mul_b = {2'd0, x_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // datapath helpers
   assign e_msb   = msb_index(req_sample);
   assign m_sq    = mul_p[61:30];
   assign diff_aq = acc_ff - tmp_ff;
   assign diff_qa = tmp_ff - acc_ff;
   assign rem_sh  = {rem_ff, quo_ff[QuoW-1]};
   assign rem_ge  = rem_sh >= {1'b0, den_ff};
   assign u_val   = cpos_ff ? (ExpBias + acc_ff[59:0]) : (ExpBias - acc_ff[59:0]);
   assign shift_v = 6'(ShiftBase) - kb_ff;
   assign rnd_v   = {4'd0, esum_ff} + (36'd1 << (shift_v - 6'd1));
   assign val_v   = rnd_v >> shift_v;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sum_b_in     = sum_b_ff;
      sum_bb_in    = sum_bb_ff;
      sum_log_in   = sum_log_ff;
      sum_bl_in    = sum_bl_ff;
      bad_in       = bad_ff;
      b_in         = b_ff;
      last_in      = last_ff;
      m_in         = m_ff;
      frac_in      = frac_ff;
      exp_in       = exp_ff;
      iter_in      = iter_ff;
      log_in       = log_ff;
      op_in        = op_ff;
      ph_in        = ph_ff;
      acc_in       = acc_ff;
      tmp_in       = tmp_ff;
      d_in         = d_ff;
      pos_in       = pos_ff;
      cpos_in      = cpos_ff;
      adc_in       = adc_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      sat_in       = sat_ff;
      use_in       = use_ff;
      cmag_in      = cmag_ff;
      kb_in        = kb_ff;
      f_in         = f_ff;
      x_in         = x_ff;
      term_in      = term_ff;
      esum_in      = esum_ff;
      k_in         = k_ff;
      rsp_valid_in = 1'b0;
      rsp_rate_in  = rsp_rate_ff;
      rsp_level_in = rsp_level_ff;
      rsp_ok_in    = rsp_ok_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_sample == 16'd0 || cnt_ff >= CntW'(MaxPoints)) begin
                  bad_in = 1'b1;
                  if (req_last_sample) begin
                     state_in = ST_SOLVE;
                  end
               end else begin
                  b_in     = req_b_value;
                  last_in  = req_last_sample;
                  exp_in   = e_msb;
                  m_in     = 31'({15'd0, req_sample} << (5'd30 - {1'b0, e_msb}));
                  frac_in  = '0;
                  iter_in  = '0;
                  state_in = ST_LOG;
               end
            end
         end

         // one fraction bit of log2 per squaring
         ST_LOG: begin
            if (m_sq[31]) begin
               frac_in = {frac_ff[18:0], 1'b1};
               m_in    = m_sq[31:1];
            end else begin
               frac_in = {frac_ff[18:0], 1'b0};
               m_in    = m_sq[30:0];
            end
            if (iter_ff == 5'(LogSteps - 1)) begin
               iter_in  = '0;
               state_in = ST_LOG_SCALE;
            end else begin
               iter_in = iter_ff + 5'd1;
            end
         end

         // log2 to ln in Q16, round half up
         ST_LOG_SCALE: begin
            log_in   = mul_p[55:36] + 20'(mul_p[35]);
            state_in = ST_ACC_BL;
         end

         ST_ACC_BL: begin
            sum_bl_in  = sum_bl_ff + 48'(mul_p[35:0]);
            sum_log_in = sum_log_ff + 26'(log_ff);
            state_in   = ST_ACC_BB;
         end

         ST_ACC_BB: begin
            sum_bb_in = sum_bb_ff + 40'(mul_p[31:0]);
            sum_b_in  = sum_b_ff + 24'(b_ff);
            cnt_in    = cnt_ff + CntW'(1);
            state_in  = last_ff ? ST_SOLVE : ST_IDLE;
         end

         ST_SOLVE: begin
            if (bad_ff || cnt_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_rate_in  = '0;
               rsp_level_in = '0;
               rsp_ok_in    = 1'b0;
            end else begin
               op_in    = OP_N_SBB;
               ph_in    = 1'b0;
               state_in = ST_PROD;
            end
         end

         // wide product: low half then high half
         ST_PROD: begin
            if (!ph_ff) begin
               acc_in = mul_p;
               ph_in  = 1'b1;
            end else begin
               acc_in   = acc_ff + {mul_p[31:0], 32'd0};
               ph_in    = 1'b0;
               state_in = ST_POST;
            end
         end

         ST_POST: begin
            case (op_ff)
               OP_N_SBB: begin
                  tmp_in   = acc_ff;
                  op_in    = OP_SB_SB;
                  state_in = ST_PROD;
               end
               OP_SB_SB: begin
                  if (tmp_ff <= acc_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_rate_in  = '0;
                     rsp_level_in = '0;
                     rsp_ok_in    = 1'b0;
                  end else begin
                     d_in     = diff_qa[40:0];
                     op_in    = OP_N_SBL;
                     state_in = ST_PROD;
                  end
               end
               OP_N_SBL: begin
                  tmp_in   = acc_ff;
                  op_in    = OP_SB_SL;
                  state_in = ST_PROD;
               end
               OP_SB_SL: begin
                  pos_in   = acc_ff >= tmp_ff;
                  num_in   = 72'(acc_ff >= tmp_ff ? diff_aq : diff_qa) << 14;
                  den_in   = d_ff;
                  use_in   = DU_ADC;
                  state_in = ST_DIV_RND;
               end
               OP_SBB_SL: begin
                  tmp_in   = acc_ff;
                  op_in    = OP_SB_SBL;
                  state_in = ST_PROD;
               end
               OP_SB_SBL: begin
                  cpos_in  = tmp_ff >= acc_ff;
                  num_in   = 72'(tmp_ff >= acc_ff ? diff_qa : diff_aq) << 8;
                  den_in   = d_ff;
                  use_in   = DU_C;
                  state_in = ST_DIV_RND;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         // round to nearest by adding half the divisor
         ST_DIV_RND: begin
            num_in   = num_ff + 72'(d_ff >> 1);
            state_in = ST_DIV_INIT;
         end

         ST_DIV_INIT: begin
            sat_in   = {1'b0, num_ff[71:32]} >= den_ff;
            rem_in   = {1'b0, num_ff[71:32]};
            quo_in   = num_ff[31:0];
            iter_in  = '0;
            state_in = ST_DIV_STEP;
         end

         // restoring division, one quotient bit per cycle
         ST_DIV_STEP: begin
            rem_in = rem_ge ? 41'(rem_sh - {1'b0, den_ff}) : rem_sh[40:0];
            quo_in = {quo_ff[QuoW-2:0], rem_ge};
            if (iter_ff == 5'(QuoW - 1)) begin
               iter_in  = '0;
               state_in = ST_DIV_POST;
            end else begin
               iter_in = iter_ff + 5'd1;
            end
         end

         ST_DIV_POST: begin
            case (use_ff)
               DU_ADC: begin
                  if (sat_ff || (pos_ff ? quo_ff[31] : (quo_ff[31] && quo_ff[30:0] != '0)))
                  begin
                     rsp_valid_in = 1'b1;
                     rsp_rate_in  = '0;
                     rsp_level_in = '0;
                     rsp_ok_in    = 1'b0;
                  end else begin
                     adc_in   = pos_ff ? quo_ff : (~quo_ff + 32'd1);
                     op_in    = OP_SBB_SL;
                     ph_in    = 1'b0;
                     state_in = ST_PROD;
                  end
               end
               DU_C: begin
                  // intercept outside the exp range saturates or flushes
                  if (cpos_ff && (sat_ff || quo_ff >= CPosLimit)) begin
                     rsp_valid_in = 1'b1;
                     rsp_rate_in  = adc_ff;
                     rsp_level_in = LevelMax;
                     rsp_ok_in    = 1'b1;
                  end else if (!cpos_ff && (sat_ff || quo_ff >= CNegLimit)) begin
                     rsp_valid_in = 1'b1;
                     rsp_rate_in  = adc_ff;
                     rsp_level_in = '0;
                     rsp_ok_in    = 1'b1;
                  end else begin
                     cmag_in  = quo_ff;
                     state_in = ST_EXP_T;
                  end
               end
               DU_TERM: begin
                  term_in = quo_ff[30:0];
                  esum_in = esum_ff + quo_ff;
                  if (k_ff == 5'(TermSteps)) begin
                     state_in = ST_EXP_OUT;
                  end else begin
                     k_in     = k_ff + 5'd1;
                     state_in = ST_EXP_TERM;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         // intercept times log2(e)
         ST_EXP_T: begin
            acc_in   = mul_p;
            state_in = ST_EXP_U;
         end

         // split into integer and fraction of the power of two
         ST_EXP_U: begin
            kb_in    = u_val[59:54];
            f_in     = u_val[53:24];
            state_in = ST_EXP_X;
         end

         ST_EXP_X: begin
            x_in     = mul_p[61:32];
            term_in  = 31'h40000000;
            esum_in  = 32'h40000000;
            k_in     = 5'd1;
            state_in = ST_EXP_TERM;
         end

         // next series term, divided by k in the shared divider
         ST_EXP_TERM: begin
            num_in   = 72'(mul_p[60:30]);
            den_in   = 41'(k_ff);
            use_in   = DU_TERM;
            state_in = ST_DIV_INIT;
         end

         ST_EXP_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_rate_in  = adc_ff;
            rsp_level_in = (val_v > 36'(LevelMax)) ? LevelMax : val_v[23:0];
            rsp_ok_in    = 1'b1;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a result ends the set
      if (rsp_valid_in) begin
         state_in   = ST_IDLE;
         cnt_in     = '0;
         sum_b_in   = '0;
         sum_bb_in  = '0;
         sum_log_in = '0;
         sum_bl_in  = '0;
         bad_in     = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         sum_b_ff     <= '0;
         sum_bb_ff    <= '0;
         sum_log_ff   <= '0;
         sum_bl_ff    <= '0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sum_b_ff     <= sum_b_in;
         sum_bb_ff    <= sum_bb_in;
         sum_log_ff   <= sum_log_in;
         sum_bl_ff    <= sum_bl_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      b_ff         <= b_in;
      last_ff      <= last_in;
      m_ff         <= m_in;
      frac_ff      <= frac_in;
      exp_ff       <= exp_in;
      iter_ff      <= iter_in;
      log_ff       <= log_in;
      op_ff        <= op_in;
      ph_ff        <= ph_in;
      acc_ff       <= acc_in;
      tmp_ff       <= tmp_in;
      d_ff         <= d_in;
      pos_ff       <= pos_in;
      cpos_ff      <= cpos_in;
      adc_ff       <= adc_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      sat_ff       <= sat_in;
      use_ff       <= use_in;
      cmag_ff      <= cmag_in;
      kb_ff        <= kb_in;
      f_ff         <= f_in;
      x_ff         <= x_in;
      term_ff      <= term_in;
      esum_ff      <= esum_in;
      k_ff         <= k_in;
      rsp_rate_ff  <= rsp_rate_in;
      rsp_level_ff <= rsp_level_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_decay_rate      = signed'(rsp_rate_ff);
   assign rsp_intercept_level = rsp_level_ff;
   assign rsp_fit_ok          = rsp_ok_ff;

   // checks
   `EDLF_ASSERT_NEXT(a_strobe_single, rsp_valid, !rsp_valid, "result strobe held two cycles")
   `EDLF_ASSERT_SAME(a_fail_zero, rsp_valid && !rsp_fit_ok, rsp_decay_rate == 32'sd0 && rsp_intercept_level == 24'd0, "failed fit carries nonzero fields")
   `EDLF_ASSERT_SAME(a_count_bound, 1'b1, cnt_ff <= CntW'(MaxPoints), "sample count beyond set size")
   `EDLF_ASSERT_SAME(a_set_cleared, rsp_valid, cnt_ff == '0 && !bad_ff, "sums not cleared with result")
   `EDLF_ASSERT_NEXT(a_accum_busy, start && !busy && req_sample != 16'd0 && cnt_ff < CntW'(MaxPoints), busy, "good sample did not start the log")

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// self-checking bench for the log-linear exponential decay fit unit
// depends on edlf_pkg and the exponential_decay_log_linear_fit_unit rtl
// voxel sets are fed through start/busy, each fit is predicted in the bench and compared
`timescale 1ns / 1ps

module testbench;
   import edlf_pkg::*;

   localparam longint unsigned LN2_Q32   = 64'd2977044472;
   localparam longint          LOG2E_Q30 = 64'sd1549082005;
   localparam longint unsigned ONE_Q30   = 64'd1 << 30;
   localparam int              SET_LIMIT = 16;
   localparam int              TOTAL_ITEMS = 1950;
   localparam longint          CYCLE_LIMIT = 8000000;

   typedef struct packed {
      logic [15:0] b_value;
      logic [15:0] sample;
      logic        last_sample;
   } sample_item_type;

   typedef struct packed {
      logic signed [31:0] decay_rate;
      logic [23:0]        intercept_level;
      logic               fit_ok;
   } fit_result_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [15:0]        req_b_value;
   logic [15:0]        req_sample;
   logic               req_last_sample;
   logic               rsp_valid;
   logic signed [31:0] rsp_decay_rate;
   logic [23:0]        rsp_intercept_level;
   logic               rsp_fit_ok;

   sample_item_type pending_samples[$];
   fit_result_type  expected_fits[$];

   // running sums of the voxel set being collected
   longint unsigned set_points, set_sum_b, set_sum_bb, set_sum_log, set_sum_blog;
   bit              set_bad;

   int     sent_items;
   int     failures;
   int     fits_checked;
   int     fits_valid;
   int     idle_pct;
   longint cycle_count;
   bit     stimulus_done;

   exponential_decay_log_linear_fit_unit dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_b_value         (req_b_value),
      .req_sample          (req_sample),
      .req_last_sample     (req_last_sample),
      .rsp_valid           (rsp_valid),
      .rsp_decay_rate      (rsp_decay_rate),
      .rsp_intercept_level (rsp_intercept_level),
      .rsp_fit_ok          (rsp_fit_ok)
   );

   // clock and reset
   initial begin
      clock = 1'b0;
   end
   always #5 clock = ~clock;

   initial begin
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // ln x in Q16: log2 by repeated squaring of the mantissa, then times ln2
   function automatic longint unsigned natural_log_q16(input logic [15:0] x);
      int              e;
      longint unsigned m, frac, l2;
      e = 15;
      while (e > 0 && x[e] == 1'b0) e--;
      m = longint'(x) << (30 - e);
      frac = 0;
      for (int i = 0; i < 20; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            frac = frac | 64'd1;
            m = m >> 1;
         end
      end
      l2 = (longint'(e) << 20) | frac;
      return (l2 * LN2_Q32 + (64'd1 << 35)) >> 36;
   endfunction

   // exp of a Q24 exponent to unsigned Q16.8 with saturation
   function automatic logic [23:0] level_from_exponent(input longint c24);
      longint          t;
      longint unsigned u, kb, f30, x, acc, term, val;
      int              s;
      if (c24 >= (64'sd12 <<< 24)) return 24'hFFFFFF;
      if (c24 <= -(64'sd9 <<< 24)) return 24'd0;
      t = c24 * LOG2E_Q30;
      u = t + (64'sd16 <<< 54);
      kb = u >> 54;
      f30 = (u >> 24) & (ONE_Q30 - 1);
      x = (f30 * LN2_Q32) >> 32;
      acc = ONE_Q30;
      term = ONE_Q30;
      for (int k = 1; k <= 20; k++) begin
         term = ((term * x) >> 30) / longint'(k);
         acc = acc + term;
      end
      s = 38 - int'(kb);
      if (s < 1) return 24'hFFFFFF;
      if (s > 62) return 24'd0;
      val = (acc + (64'd1 << (s - 1))) >> s;
      return (val > 64'hFFFFFF) ? 24'hFFFFFF : val[23:0];
   endfunction

   // solve the 2x2 normal equations over the collected set
   function automatic fit_result_type solve_voxel_fit();
      fit_result_type  r;
      longint unsigned a, bb, d, p, q, mag, r30, cm, qq, rr, cmag;
      bit              pos, cpos;
      longint          c24;
      r = '0;
      if (set_bad || set_points == 0) return r;
      a = set_points * set_sum_bb;
      bb = set_sum_b * set_sum_b;
      if (a <= bb) return r;
      d = a - bb;
      p = set_points * set_sum_blog;
      q = set_sum_b * set_sum_log;
      pos = (q >= p);
      mag = pos ? q - p : p - q;
      r30 = ((mag << 14) + d / 2) / d;
      if (pos ? (r30 > 64'h7FFFFFFF) : (r30 > 64'h80000000)) return r;
      p = set_sum_bb * set_sum_log;
      q = set_sum_b * set_sum_blog;
      cpos = (p >= q);
      cm = cpos ? p - q : q - p;
      qq = cm / d;
      rr = cm % d;
      if (qq >= ONE_Q30) begin
         r.intercept_level = cpos ? 24'hFFFFFF : 24'd0;
      end else begin
         cmag = qq * 256 + ((rr << 8) + d / 2) / d;
         c24 = cpos ? longint'(cmag) : -longint'(cmag);
         r.intercept_level = level_from_exponent(c24);
      end
      r.decay_rate = pos ? r30[31:0] : (~r30[31:0] + 32'd1);
      r.fit_ok = 1'b1;
      return r;
   endfunction

   // fold one accepted request into the set, queue the fit on the last one
   task automatic absorb_sample(input sample_item_type it);
      longint unsigned l;
      if (it.sample == 16'd0 || set_points >= SET_LIMIT) begin
         set_bad = 1'b1;
      end else begin
         l = natural_log_q16(it.sample);
         set_points++;
         set_sum_b += it.b_value;
         set_sum_bb += longint'(it.b_value) * longint'(it.b_value);
         set_sum_log += l;
         set_sum_blog += longint'(it.b_value) * l;
      end
      if (it.last_sample) begin
         expected_fits.push_back(solve_voxel_fit());
         set_points = 0;
         set_sum_b = 0;
         set_sum_bb = 0;
         set_sum_log = 0;
         set_sum_blog = 0;
         set_bad = 1'b0;
      end
   endtask

   task automatic add_sample(input int b, input int s, input bit last);
      sample_item_type it;
      it.b_value = b[15:0];
      it.sample = s[15:0];
      it.last_sample = last;
      pending_samples.push_back(it);
   endtask

   // well-formed decay set with random content
   task automatic add_decay_set(input int count);
      real s0, adc, v;
      int  b, bmax;
      s0 = $urandom_range(65535, 1);
      adc = $urandom_range(4000) * 1.0e-6;
      if ($urandom_range(9) == 0) adc = -adc;
      bmax = ($urandom_range(9) == 0) ? 65535 : 3000;
      for (int i = 0; i < count; i++) begin
         b = $urandom_range(bmax);
         v = s0 * $exp(-adc * b) *
             (1.0 + (real'($urandom_range(200)) - 100.0) * 1.0e-3);
         if (v < 1.0) v = 1.0;
         if (v > 65535.0) v = 65535.0;
         add_sample(b, int'(v), i == count - 1);
      end
   endtask

   // noise set: any field value, zero samples and overfull sets included
   task automatic add_noise_set(input int count);
      int s;
      for (int i = 0; i < count; i++) begin
         s = ($urandom_range(7) == 0) ? 0 : $urandom_range(65535);
         add_sample($urandom_range(65535), s, i == count - 1);
      end
   endtask

   // stimulus
   initial begin
      int kind, n;
      set_points = 0;
      set_sum_b = 0;
      set_sum_bb = 0;
      set_sum_log = 0;
      set_sum_blog = 0;
      set_bad = 1'b0;
      stimulus_done = 1'b0;
      // single sample, singular
      add_sample(100, 1000, 1'b1);
      // all b equal, singular
      add_sample(500, 2000, 1'b0);
      add_sample(500, 3000, 1'b1);
      // field extremes, steep decay
      add_sample(0, 65535, 1'b0);
      add_sample(65535, 1, 1'b1);
      // rising signal, negative rate
      add_sample(0, 1, 1'b0);
      add_sample(65535, 65535, 1'b1);
      // rate too steep for Q2.30
      add_sample(0, 65535, 1'b0);
      add_sample(1, 1, 1'b1);
      // zero sample spoils the set
      add_sample(0, 1000, 1'b0);
      add_sample(800, 0, 1'b0);
      add_sample(1600, 300, 1'b1);
      // intercept above the Q16.8 range saturates
      add_sample(1000, 60000, 1'b0);
      add_sample(2000, 20000, 1'b1);
      // one sample more than a set holds
      for (int k = 0; k <= SET_LIMIT; k++) begin
         add_sample(k * 100, 40000 - k * 2000, k == SET_LIMIT);
      end
      while (pending_samples.size() < TOTAL_ITEMS) begin
         kind = $urandom_range(99);
         if (kind < 80) begin
            n = ($urandom_range(9) < 8) ? $urandom_range(6, 2) : $urandom_range(16, 7);
            add_decay_set(n);
         end else begin
            n = ($urandom_range(9) == 0) ? $urandom_range(20, 17) : $urandom_range(5, 1);
            add_noise_set(n);
         end
      end
      stimulus_done = 1'b1;
   end

   // request driver
   always @(posedge clock) begin
      bit              took;
      sample_item_type nxt;
      if (reset) begin
         start <= 1'b0;
         req_b_value <= '0;
         req_sample <= '0;
         req_last_sample <= 1'b0;
         sent_items <= 0;
      end else begin
         took = start && !busy;
         if (took) begin
            absorb_sample(pending_samples.pop_front());
            sent_items <= sent_items + 1;
         end
         idle_pct = (sent_items < 650) ? 16 : (sent_items < 1300) ? 88 : 0;
         if (!start || took) begin
            if (stimulus_done && pending_samples.size() > 0 &&
                $urandom_range(99) >= idle_pct) begin
               nxt = pending_samples[0];
               start <= 1'b1;
               req_b_value <= nxt.b_value;
               req_sample <= nxt.sample;
               req_last_sample <= nxt.last_sample;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      fit_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_fits.size() == 0) begin
            $display("%0t: unexpected result decay_rate=%0d intercept_level=%0d fit_ok=%0b",
                     $time, rsp_decay_rate, rsp_intercept_level, rsp_fit_ok);
            failures++;
         end else begin
            want = expected_fits.pop_front();
            fits_checked++;
            if (want.fit_ok) fits_valid++;
            if (rsp_decay_rate !== want.decay_rate) begin
               $display("%0t: decay_rate expected %0d actual %0d",
                        $time, want.decay_rate, rsp_decay_rate);
               failures++;
            end
            if (rsp_intercept_level !== want.intercept_level) begin
               $display("%0t: intercept_level expected %0d actual %0d",
                        $time, want.intercept_level, rsp_intercept_level);
               failures++;
            end
            if (rsp_fit_ok !== want.fit_ok) begin
               $display("%0t: fit_ok expected %0b actual %0b",
                        $time, want.fit_ok, rsp_fit_ok);
               failures++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("testbench failed");
         $finish;
      end
   end

   // end of run
   initial begin
      failures = 0;
      fits_checked = 0;
      fits_valid = 0;
      cycle_count = 0;
      wait (stimulus_done);
      wait (pending_samples.size() == 0 && !start);
      wait (expected_fits.size() == 0);
      repeat (1000) @(posedge clock);
      if (expected_fits.size() != 0) begin
         $display("%0d fits never arrived", expected_fits.size());
         failures++;
      end
      $display("%0d samples sent, %0d voxel fits checked (%0d valid, %0d rejected)",
               sent_items, fits_checked, fits_valid, fits_checked - fits_valid);
      if (failures == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/edlf_pkg.sv
hdl/exponential_decay_log_linear_fit_unit.sv
bench/testbench.sv
